// File: hdl/pbcr_pkg.sv
// ----------------------------------------------------------------------------
// pbcr_pkg
// Shared types, codes and the nibble character table of the byte cipher
// run decoder.
// ----------------------------------------------------------------------------
package pbcr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned RUN_W      = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned Q_DEPTH    = 4;
   localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

   // cipher modes
   localparam logic [MODE_W-1:0] MODE_SUB     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB_XOR = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADD_XOR = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MINUS_F = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RAW     = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY  = 2'd1;

   localparam logic [BYTE_W-1:0] KEY_BASE  = 8'h40;
   localparam logic [BYTE_W-1:0] XOR_MASK  = 8'hC3;
   localparam logic [BYTE_W-1:0] MINUS_OFS = 8'h0F;
   localparam logic [BYTE_W-1:0] SEP_BYTE  = 8'hFF;

   // result slots of one queue entry
   localparam int unsigned SLOT_C0    = 0;
   localparam int unsigned SLOT_C1    = 1;
   localparam int unsigned SLOT_DELIM = 2;
   localparam int unsigned SLOTS      = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] c0;
      logic [BYTE_W-1:0] c1;
      logic [SLOTS-1:0]  mask;
   } entry_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } q_stat_type;

   function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] c;
      case (nib)
         4'h1:    c = 8'h20;
         4'h2:    c = 8'h2D;
         4'h3:    c = 8'h2E;
         4'h4:    c = 8'h30;
         4'h5:    c = 8'h31;
         4'h6:    c = 8'h32;
         4'h7:    c = 8'h33;
         4'h8:    c = 8'h34;
         4'h9:    c = 8'h35;
         4'hA:    c = 8'h36;
         4'hB:    c = 8'h37;
         4'hC:    c = 8'h38;
         4'hD:    c = 8'h39;
         4'hE:    c = 8'h0A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: hdl/pbcr_front.sv
// ----------------------------------------------------------------------------
// pbcr_front
// Deciphers each accepted byte, tracks segment and run state and writes
// the results that the byte causes into the queue as one entry.
// ----------------------------------------------------------------------------
module pbcr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pbcr_pkg::BYTE_W-1:0]         req_in_byte,
   input  logic                                req_end_of_packet,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pbcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbcr_pkg::BYTE_W-1:0]         csr_data,
   input  pbcr_pkg::q_stat_type                q_stat,
   output logic                                push,
   output pbcr_pkg::entry_type                 push_entry
);

   logic [pbcr_pkg::MODE_W-1:0] cipher_mode_ff, cipher_mode_in;
   logic [pbcr_pkg::BYTE_W-1:0] cipher_key_ff, cipher_key_in;
   logic [pbcr_pkg::RUN_W-1:0]  run_remaining_ff, run_remaining_in;
   logic                        run_is_packed_ff, run_is_packed_in;
   logic                        segment_nonempty_ff, segment_nonempty_in;

   logic                        accept;
   logic                        marked;
   logic [pbcr_pkg::BYTE_W-1:0] key;
   logic [pbcr_pkg::BYTE_W-1:0] b;
   logic [3:0]                  hi, lo;
   logic                        hi_ok, lo_ok;
   logic [pbcr_pkg::RUN_W-1:0]  run_after_hi;
   pbcr_pkg::entry_type         entry;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign marked    = (cipher_mode_ff != pbcr_pkg::MODE_RAW);

   always_comb begin
      key = pbcr_pkg::KEY_BASE + cipher_key_ff;
      unique case (cipher_mode_ff)
         pbcr_pkg::MODE_SUB:     b = req_in_byte - key;
         pbcr_pkg::MODE_ADD:     b = req_in_byte + key;
         pbcr_pkg::MODE_SUB_XOR: b = (req_in_byte - key) ^ pbcr_pkg::XOR_MASK;
         pbcr_pkg::MODE_ADD_XOR: b = (req_in_byte + key) ^ pbcr_pkg::XOR_MASK;
         pbcr_pkg::MODE_RAW:     b = req_in_byte;
         default:                b = req_in_byte - pbcr_pkg::MINUS_OFS;
      endcase
   end

   always_comb begin
      hi           = b[7:4];
      lo           = b[3:0];
      hi_ok        = (run_remaining_ff != '0) && (hi != 4'h0) && (hi != 4'hF);
      run_after_hi = run_remaining_ff - {{(pbcr_pkg::RUN_W-1){1'b0}}, hi_ok};
      // a run that ends on the high nibble drops the low nibble
      lo_ok        = (run_after_hi != '0) && (lo != 4'h0) && (lo != 4'hF);

      entry               = '0;
      run_remaining_in    = run_remaining_ff;
      run_is_packed_in    = run_is_packed_ff;
      segment_nonempty_in = segment_nonempty_ff;

      if (accept) begin
         if (b == pbcr_pkg::SEP_BYTE) begin
            entry.mask[pbcr_pkg::SLOT_DELIM] = marked;
            run_remaining_in    = '0;
            run_is_packed_in    = 1'b0;
            segment_nonempty_in = 1'b0;
         end else begin
            segment_nonempty_in = 1'b1;
            if (run_remaining_ff == '0) begin
               run_remaining_in = b[pbcr_pkg::RUN_W-1:0];
               run_is_packed_in = b[7];
            end else if (run_is_packed_ff) begin
               entry.c0 = pbcr_pkg::nibble_char(hi);
               entry.c1 = pbcr_pkg::nibble_char(lo);
               entry.mask[pbcr_pkg::SLOT_C0] = hi_ok;
               entry.mask[pbcr_pkg::SLOT_C1] = lo_ok;
               run_remaining_in = run_after_hi - {{(pbcr_pkg::RUN_W-1){1'b0}}, lo_ok};
            end else begin
               entry.c0 = b ^ 8'hFF;
               entry.mask[pbcr_pkg::SLOT_C0] = 1'b1;
               run_remaining_in = run_remaining_ff - {{(pbcr_pkg::RUN_W-1){1'b0}}, 1'b1};
            end
            if (req_end_of_packet) begin
               entry.mask[pbcr_pkg::SLOT_DELIM] = marked && segment_nonempty_in;
            end
         end
         if (req_end_of_packet) begin
            run_remaining_in    = '0;
            run_is_packed_in    = 1'b0;
            segment_nonempty_in = 1'b0;
         end
      end
   end

   assign push       = accept && (entry.mask != '0);
   assign push_entry = entry;

   always_comb begin
      cipher_mode_in = cipher_mode_ff;
      cipher_key_in  = cipher_key_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbcr_pkg::CSR_MODE: cipher_mode_in = csr_data[pbcr_pkg::MODE_W-1:0];
            pbcr_pkg::CSR_KEY:  cipher_key_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mode_ff      <= pbcr_pkg::MODE_MINUS_F;
         cipher_key_ff       <= '0;
         run_remaining_ff    <= '0;
         run_is_packed_ff    <= 1'b0;
         segment_nonempty_ff <= 1'b0;
      end else begin
         cipher_mode_ff      <= cipher_mode_in;
         cipher_key_ff       <= cipher_key_in;
         run_remaining_ff    <= run_remaining_in;
         run_is_packed_ff    <= run_is_packed_in;
         segment_nonempty_ff <= segment_nonempty_in;
      end
   end

   a_eop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_packet |=>
         run_remaining_ff == '0 && !run_is_packed_ff && !segment_nonempty_ff)
      else $error("packet end left run state open");

   a_eop_delim: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_packet && marked |-> push && push_entry.mask[pbcr_pkg::SLOT_DELIM])
      else $error("packet end in marked mode gave no delimiter");

   a_sep_clears: assert property (@(posedge clock) disable iff (reset)
      accept && b == pbcr_pkg::SEP_BYTE |=> run_remaining_ff == '0 && !segment_nonempty_ff)
      else $error("separator did not close the segment");

endmodule

// File: hdl/pbcr_queue.sv
// ----------------------------------------------------------------------------
// pbcr_queue
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module pbcr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pbcr_pkg::entry_type  push_entry,
   input  logic                 pop,
   output pbcr_pkg::entry_type  head_entry,
   output pbcr_pkg::q_stat_type q_stat
);

   pbcr_pkg::entry_type            slot_ff [pbcr_pkg::Q_DEPTH];
   logic [pbcr_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pbcr_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pbcr_pkg::Q_CNT_W-1:0]   count_ff, count_in;

   assign q_stat.full     = (count_ff == pbcr_pkg::Q_CNT_W'(pbcr_pkg::Q_DEPTH));
   assign q_stat.nonempty = (count_ff != '0);
   assign head_entry      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.nonempty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pbcr_pkg::Q_CNT_W'(pbcr_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

// File: hdl/pbcr_back.sv
// ----------------------------------------------------------------------------
// pbcr_back
// Takes entries from the queue and hands out their results one beat at a
// time through an output register, flagging the last result of each byte.
// ----------------------------------------------------------------------------
module pbcr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pbcr_pkg::entry_type         head_entry,
   input  pbcr_pkg::q_stat_type        q_stat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pbcr_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_is_delimiter,
   output logic                        rsp_last_of_run
);

   logic [pbcr_pkg::BYTE_W-1:0] cur_c0_ff, cur_c0_in;
   logic [pbcr_pkg::BYTE_W-1:0] cur_c1_ff, cur_c1_in;
   logic [pbcr_pkg::SLOTS-1:0]  cur_mask_ff, cur_mask_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pbcr_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_delim_ff, rsp_delim_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        out_free;
   logic                        take;
   logic [pbcr_pkg::SLOTS-1:0]  mask_left;
   logic [pbcr_pkg::BYTE_W-1:0] sel_byte;
   logic                        sel_delim;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = out_free && (cur_mask_ff != '0);

   always_comb begin
      // lowest pending slot goes out first
      mask_left = cur_mask_ff;
      sel_byte  = pbcr_pkg::SEP_BYTE;
      sel_delim = 1'b1;
      if (cur_mask_ff[pbcr_pkg::SLOT_C0]) begin
         sel_byte  = cur_c0_ff;
         sel_delim = 1'b0;
         mask_left[pbcr_pkg::SLOT_C0] = 1'b0;
      end else if (cur_mask_ff[pbcr_pkg::SLOT_C1]) begin
         sel_byte  = cur_c1_ff;
         sel_delim = 1'b0;
         mask_left[pbcr_pkg::SLOT_C1] = 1'b0;
      end else begin
         mask_left[pbcr_pkg::SLOT_DELIM] = 1'b0;
      end
   end

   // refill the entry register as soon as its last result moves out
   assign pop = q_stat.nonempty && ((cur_mask_ff == '0) || (take && mask_left == '0));

   always_comb begin
      cur_c0_in   = cur_c0_ff;
      cur_c1_in   = cur_c1_ff;
      cur_mask_in = take ? mask_left : cur_mask_ff;
      if (pop) begin
         cur_c0_in   = head_entry.c0;
         cur_c1_in   = head_entry.c1;
         cur_mask_in = head_entry.mask;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_delim_in = rsp_delim_ff;
      rsp_last_in  = rsp_last_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sel_byte;
         rsp_delim_in = sel_delim;
         rsp_last_in  = (mask_left == '0);
      end
   end

   always_ff @(posedge clock) begin
      cur_c0_ff   <= cur_c0_in;
      cur_c1_ff   <= cur_c1_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_delim_ff <= rsp_delim_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff  <= cur_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_is_delimiter = rsp_delim_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   a_delim_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_delim_ff |-> rsp_byte_ff == pbcr_pkg::SEP_BYTE)
      else $error("delimiter beat without separator byte");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("pending result not moved to output");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> cur_mask_ff != '0)
      else $error("empty entry loaded from queue");

endmodule

// File: hdl/packet_byte_cipher_run_decoder.sv
// ----------------------------------------------------------------------------
// packet_byte_cipher_run_decoder
// Byte cipher and run decoder: deciphers packet bytes, splits segments and
// expands packed and plain runs into characters with segment delimiters.
// ----------------------------------------------------------------------------
// path: a byte's results pass the queue, the entry register and output register
// throughput: one result beat per cycle while rsp_stall is low; a byte has
//   1 to 3 results, all sent through the single output register; bytes with
//   no result push no entry, and a 4-entry queue absorbs the difference
// reset: synchronous; clears run state, queue and output, mode 4 and key 0
module packet_byte_cipher_run_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pbcr_pkg::BYTE_W-1:0]         req_in_byte,
   input  logic                                req_end_of_packet,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pbcr_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                rsp_is_delimiter,
   output logic                                rsp_last_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbcr_pkg::BYTE_W-1:0]         csr_data
);

   logic                 push;
   logic                 pop;
   pbcr_pkg::entry_type  push_entry;
   pbcr_pkg::entry_type  head_entry;
   pbcr_pkg::q_stat_type q_stat;

   assign csr_ready = 1'b1;

   pbcr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_packet (req_end_of_packet),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_stat            (q_stat),
      .push              (push),
      .push_entry        (push_entry)
   );

   pbcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   pbcr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .q_stat           (q_stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_delimiter (rsp_is_delimiter),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
